### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ssba_pkg.sv
// ---------------------------------------------------------------------------
// ssba_pkg
// Types and constants shared by the slot binding allocator modules.
// ---------------------------------------------------------------------------
package ssba_pkg;

  // Field widths
  localparam int ID_W    = 32;
  localparam int TAG_W   = 2;
  localparam int SCORE_W = 8;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 5;
  localparam int UNITS_W = 6;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_ACTIVATE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REL_SCOPE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REL_ID     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DECAY      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

  // Register map (index = paddr[2])
  localparam logic REG_UNITS = 1'b0;
  localparam logic [UNITS_W-1:0] UNITS_RESET = 6'd16;

  // Score given to a freshly bound slot
  localparam logic [SCORE_W-1:0] FRESH_SCORE = 8'd200;
  // Best-score start value: above any 8-bit score
  localparam logic [SCORE_W:0] NO_SCORE_LIMIT = 9'h100;

  // One slot entry as stored in the table
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               pin;
    logic [TAG_W-1:0]   scope;
    logic [SCORE_W-1:0] score;
  } ssba_entry_t;

  localparam int ENTRY_W = $bits(ssba_entry_t);

  // Per-entry evaluation from the shared slot unit
  typedef struct packed {
    logic        id_hit;
    logic        free_lower;
    logic        scope_hit;
    ssba_entry_t upd;
  } ssba_unit_res_t;

endpackage

### rtl/scored_slot_binding_allocator_core.sv
// ---------------------------------------------------------------------------
// scored_slot_binding_allocator_core
// Binds resource ids to slots with pin, scope tag and age score per slot.
// ---------------------------------------------------------------------------
// Sequence: idle takes an item; for valid kinds the scan step walks the table one
//   slot per cycle, over n slots for activate and release (n = active units)
//   and over MAX_SLOTS for decay and clear; activate and release id then pass
//   a write-back step, and every item ends in the finish step. One item at a
//   time: in_stall is high outside idle, and finish waits on a stalled result.
// Reset: rst_n (sync, active low) sets units_in_use to 16 and clears all
//   per-slot valid bits, so every slot reads as all zero; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scored_slot_binding_allocator_core #(
  parameter int MAX_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_resource_id,
  input  logic [1:0]  in_scope_tag,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_slot,
  output logic        out_slot_valid,
  output logic        out_rebind,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SLOT_W = ssba_pkg::SLOT_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Control registers
  logic [1:0]                    state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ssba_pkg::UNITS_W-1:0]  units_r;
  logic [MAX_SLOTS-1:0]          vld_r;

  // Item and scan registers
  logic [ssba_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [ssba_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [ssba_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]              p_idx_r, p_idx_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic                          matched_r, matched_nxt;
  logic                          found_r, found_nxt;
  logic [ssba_pkg::SCORE_W:0]    best_r, best_nxt;
  logic [IDX_W-1:0]              pick_r, pick_nxt;
  ssba_pkg::ssba_entry_t         held_r, held_nxt;

  // Result registers
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic                          slot_valid_r, slot_valid_nxt;
  logic                          rebind_r, rebind_nxt;

  // Table and unit signals
  logic                          ram_we, ram_re;
  logic [IDX_W-1:0]              ram_waddr, rd_idx;
  logic [ssba_pkg::ENTRY_W-1:0]  ram_q;
  ssba_pkg::ssba_entry_t         rd_word, unit_entry;
  ssba_pkg::ssba_unit_res_t      ures;
  logic [CNT_W-1:0]              n_units, last;
  logic                          cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ssba_pkg::REG_UNITS);
  assign prdata = (paddr[2] == ssba_pkg::REG_UNITS) ? 32'(units_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r <= ssba_pkg::UNITS_RESET;
    end else if (cfg_wr) begin
      units_r <= pwdata[ssba_pkg::UNITS_W-1:0];
    end
  end

  // Active slot count, clamped to the table size
  assign n_units = (32'(units_r) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(units_r);
  assign last    = (kind_r == ssba_pkg::KIND_DECAY || kind_r == ssba_pkg::KIND_CLEAR) ?
                   CNT_W'(MAX_SLOTS) : n_units;

  // Slot table
  ssba_ram #(
    .WIDTH (ssba_pkg::ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ures.upd),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // Slots never written read as zero
  assign rd_word    = rd_vld_r ? ssba_pkg::ssba_entry_t'(ram_q) : '0;
  assign unit_entry = (state_r == ST_WB) ? held_r : rd_word;
  assign rd_idx     = cnt_r[IDX_W-1:0];

  ssba_slot_unit u_unit (
    .entry (unit_entry),
    .kind  (kind_r),
    .id    (id_r),
    .tag   (tag_r),
    .best  (best_r),
    .res   (ures)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    tag_nxt        = tag_r;
    cnt_nxt        = cnt_r;
    p_vld_nxt      = p_vld_r;
    p_idx_nxt      = p_idx_r;
    rd_vld_nxt     = rd_vld_r;
    matched_nxt    = matched_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    pick_nxt       = pick_r;
    held_nxt       = held_r;
    slot_nxt       = slot_r;
    slot_valid_nxt = slot_valid_r;
    rebind_nxt     = rebind_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = p_idx_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          id_nxt      = in_resource_id;
          tag_nxt     = in_scope_tag;
          cnt_nxt     = '0;
          p_vld_nxt   = 1'b0;
          matched_nxt = 1'b0;
          found_nxt   = 1'b0;
          best_nxt    = ssba_pkg::NO_SCORE_LIMIT;
          pick_nxt    = '0;
          state_nxt   = (in_kind > ssba_pkg::KIND_CLEAR) ? ST_FIN : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue the next slot read
        if (cnt_r < last) begin
          ram_re     = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
          p_vld_nxt  = 1'b1;
          p_idx_nxt  = rd_idx;
          rd_vld_nxt = vld_r[rd_idx];
        end else begin
          p_vld_nxt = 1'b0;
        end
        // evaluate the slot read last cycle
        if (p_vld_r) begin
          case (kind_r)
            ssba_pkg::KIND_ACTIVATE: begin
              if (!matched_r) begin
                if (ures.id_hit) begin
                  matched_nxt = 1'b1;
                  pick_nxt    = p_idx_r;
                end else if (ures.free_lower) begin
                  found_nxt = 1'b1;
                  best_nxt  = {1'b0, rd_word.score};
                  pick_nxt  = p_idx_r;
                end
              end
            end
            ssba_pkg::KIND_REL_ID: begin
              if (!matched_r && ures.id_hit) begin
                matched_nxt = 1'b1;
                pick_nxt    = p_idx_r;
                held_nxt    = rd_word;
              end
            end
            ssba_pkg::KIND_REL_SCOPE: begin
              ram_we = ures.scope_hit;
            end
            ssba_pkg::KIND_DECAY,
            ssba_pkg::KIND_CLEAR: begin
              ram_we = 1'b1;
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end
        if (cnt_r == last && !p_vld_r) begin
          state_nxt = (kind_r == ssba_pkg::KIND_ACTIVATE || kind_r == ssba_pkg::KIND_REL_ID) ?
                      ST_WB : ST_FIN;
        end
      end

      ST_WB: begin
        // write back the chosen or released slot
        ram_waddr = pick_r;
        ram_we    = (kind_r == ssba_pkg::KIND_ACTIVATE) ? (matched_r || found_r) : matched_r;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (kind_r == ssba_pkg::KIND_ACTIVATE) begin
            slot_valid_nxt = matched_r || found_r;
            rebind_nxt     = matched_r ? (id_r == '0) : found_r;
          end else if (kind_r == ssba_pkg::KIND_REL_ID) begin
            slot_valid_nxt = matched_r;
            rebind_nxt     = 1'b0;
          end else begin
            slot_valid_nxt = 1'b0;
            rebind_nxt     = 1'b0;
          end
          slot_nxt  = slot_valid_nxt ? SLOT_W'(pick_r) : '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    tag_r        <= tag_nxt;
    cnt_r        <= cnt_nxt;
    p_vld_r      <= p_vld_nxt;
    p_idx_r      <= p_idx_nxt;
    rd_vld_r     <= rd_vld_nxt;
    matched_r    <= matched_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    pick_r       <= pick_nxt;
    held_r       <= held_nxt;
    slot_r       <= slot_nxt;
    slot_valid_r <= slot_valid_nxt;
    rebind_r     <= rebind_nxt;
  end

  // Ports
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_slot       = slot_r;
  assign out_slot_valid = slot_valid_r;
  assign out_rebind     = rebind_r;

  // Checks
  `ASSERT_CLK(a_result_from_fin, clk, rst_n,
    $rose(out_valid) |-> $past(state_r) == ST_FIN, "result appeared outside finish step")
  `ASSERT_CLK(a_slot_zero_when_none, clk, rst_n,
    out_valid && !out_slot_valid |-> out_slot == '0, "slot nonzero without a valid slot")
  `ASSERT_CLK(a_rebind_needs_slot, clk, rst_n,
    out_valid && out_rebind |-> out_slot_valid, "rebind flagged without a slot")
  `ASSERT_ALWAYS(a_scan_bound, clk,
    state_r == ST_SCAN |-> cnt_r <= CNT_W'(MAX_SLOTS), "scan counter past table end")

endmodule

### rtl/ssba_ram.sv
// ---------------------------------------------------------------------------
// ssba_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ssba_ram #(
  parameter int WIDTH = 43,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ssba_slot_unit.sv
// ---------------------------------------------------------------------------
// ssba_slot_unit
// Shared per-slot compare and update unit, reused on every scan and write-back step.
// ---------------------------------------------------------------------------
module ssba_slot_unit (
  input  ssba_pkg::ssba_entry_t                 entry,
  input  logic [ssba_pkg::KIND_W-1:0]           kind,
  input  logic [ssba_pkg::ID_W-1:0]             id,
  input  logic [ssba_pkg::TAG_W-1:0]            tag,
  input  logic [ssba_pkg::SCORE_W:0]            best,
  output ssba_pkg::ssba_unit_res_t              res
);

  logic [ssba_pkg::SCORE_W-1:0] score_dec;

  // Decrement with floor at zero
  assign score_dec = entry.score - ssba_pkg::SCORE_W'(entry.score != '0);

  always_comb begin
    res.id_hit     = (entry.id == id);
    res.free_lower = !entry.pin && ({1'b0, entry.score} < best);
    res.scope_hit  = entry.pin && (entry.scope == tag);
    res.upd        = entry;
    case (kind)
      ssba_pkg::KIND_ACTIVATE: begin
        res.upd.id    = id;
        res.upd.pin   = 1'b1;
        res.upd.scope = tag;
        res.upd.score = ssba_pkg::FRESH_SCORE;
      end
      ssba_pkg::KIND_REL_SCOPE: begin
        res.upd.pin   = 1'b0;
        res.upd.score = score_dec;
      end
      ssba_pkg::KIND_REL_ID: begin
        res.upd.pin = 1'b0;
      end
      ssba_pkg::KIND_DECAY: begin
        res.upd.score = score_dec;
      end
      ssba_pkg::KIND_CLEAR: begin
        res.upd.id = '0;
      end
      default: begin
        res.upd = entry;
      end
    endcase
  end

endmodule

### test/slot_binding_checker.sv
// ----------------------------------------------------------------------------
// slot_binding_checker
// Watches the input, result and configuration ports of the slot binding
// allocator. It keeps its own copy of the slot table, works out the result
// of every input transfer, and compares each result transfer against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module slot_binding_checker #(
  parameter int MAX_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_resource_id,
  input  logic [1:0]  in_scope_tag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  out_slot,
  input  logic        out_slot_valid,
  input  logic        out_rebind,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          errors
);

  typedef struct packed {
    logic [ssba_pkg::SLOT_W-1:0] slot;
    logic                        slot_valid;
    logic                        rebind;
  } slot_result_t;

  // Shadow slot table and register
  logic [ssba_pkg::ID_W-1:0]    slot_owner  [MAX_SLOTS];
  logic                         slot_pinned [MAX_SLOTS];
  logic [ssba_pkg::TAG_W-1:0]   slot_tag    [MAX_SLOTS];
  logic [ssba_pkg::SCORE_W-1:0] slot_age    [MAX_SLOTS];
  logic [ssba_pkg::UNITS_W-1:0] units;

  slot_result_t expected_results [$];

  // Apply one command to the shadow table, return what the block should say
  task automatic predict_binding(input logic [ssba_pkg::KIND_W-1:0] kind,
                                 input logic [ssba_pkg::ID_W-1:0] id,
                                 input logic [ssba_pkg::TAG_W-1:0] tag,
                                 output slot_result_t res);
    int         n;
    int         pick;
    bit         hit;
    logic [ssba_pkg::SCORE_W:0] best;
    res = '0;
    n = (units > MAX_SLOTS) ? MAX_SLOTS : int'(units);
    case (kind)
      ssba_pkg::KIND_ACTIVATE: begin
        hit = 1'b0;
        pick = 0;
        best = ssba_pkg::NO_SCORE_LIMIT;
        // first id hit wins; otherwise lowest-score unpinned slot
        for (int u = 0; u < n; u++) begin
          if (slot_owner[u] == id) begin
            pick = u;
            hit = 1'b1;
            break;
          end
          if (!slot_pinned[u] && {1'b0, slot_age[u]} < best) begin
            best = {1'b0, slot_age[u]};
            pick = u;
            hit = 1'b1;
          end
        end
        if (hit) begin
          res.rebind     = (slot_owner[pick] != id) || (id == '0);
          res.slot       = ssba_pkg::SLOT_W'(pick);
          res.slot_valid = 1'b1;
          slot_owner[pick]  = id;
          slot_age[pick]    = ssba_pkg::FRESH_SCORE;
          slot_pinned[pick] = 1'b1;
          slot_tag[pick]    = tag;
        end
      end
      ssba_pkg::KIND_REL_SCOPE: begin
        for (int u = 0; u < n; u++) begin
          if (slot_pinned[u] && slot_tag[u] == tag) begin
            slot_pinned[u] = 1'b0;
            if (slot_age[u] != '0) slot_age[u] = slot_age[u] - 1'b1;
          end
        end
      end
      ssba_pkg::KIND_REL_ID: begin
        for (int u = 0; u < n; u++) begin
          if (slot_owner[u] == id) begin
            slot_pinned[u] = 1'b0;
            res.slot       = ssba_pkg::SLOT_W'(u);
            res.slot_valid = 1'b1;
            break;
          end
        end
      end
      // decay and clear touch the whole table regardless of units
      ssba_pkg::KIND_DECAY: begin
        for (int u = 0; u < MAX_SLOTS; u++)
          if (slot_age[u] != '0) slot_age[u] = slot_age[u] - 1'b1;
      end
      ssba_pkg::KIND_CLEAR: begin
        for (int u = 0; u < MAX_SLOTS; u++) slot_owner[u] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      errors = errors + 1;
    end
  endtask

  // Monitor: register writes, result transfers, then input transfers
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst_n) begin
      units = ssba_pkg::UNITS_RESET;
      for (int u = 0; u < MAX_SLOTS; u++) begin
        slot_owner[u]  = '0;
        slot_pinned[u] = 1'b0;
        slot_tag[u]    = '0;
        slot_age[u]    = '0;
      end
      expected_results.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == ssba_pkg::REG_UNITS)
        units = pwdata[ssba_pkg::UNITS_W-1:0];
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual slot=%0d valid=%0d rebind=%0d",
                   $time, out_slot, out_slot_valid, out_rebind);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          check_field("slot", want.slot, out_slot);
          check_field("slot_valid", want.slot_valid, out_slot_valid);
          check_field("rebind", want.rebind, out_rebind);
        end
      end
      if (in_valid && !in_stall) begin
        predict_binding(in_kind, in_resource_id, in_scope_tag, want);
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

### test/scored_slot_binding_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// scored_slot_binding_allocator_core_tb
// Drives the slot binding allocator with a directed opening and then
// randomized phases, each at its own units_in_use setting, with random
// input gaps and result stalls in all but the no-idle phases. Checking is
// left to slot_binding_checker; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module scored_slot_binding_allocator_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 80;
  localparam int POOL_MAX    = 40;
  localparam logic [ssba_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [ssba_pkg::KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [ssba_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [31:0] in_resource_id;
  logic [1:0]  in_scope_tag;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_slot;
  logic        out_slot_valid;
  logic        out_rebind;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int errors;
  int cycles = 0;
  int stall_max = 14;
  int stall_left = 0;
  bit no_idle = 1'b0;
  logic result_taken = 1'b0;

  logic [31:0] id_pool [POOL_MAX];
  int pool_size = 4;
  int unit_plan [11] = '{1, 4, 32, 0, 63, 7, 33, 2, 0, 16, 32};

  always #6 clk = ~clk;

  scored_slot_binding_allocator_core uut (.*);

  slot_binding_checker #(.MAX_SLOTS(32)) binding_check (.*);

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: after each transfer draw a fresh stall length
  always @(posedge clk) result_taken <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (result_taken) stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One input transfer; entered and left at a falling edge
  task automatic send_item(input logic [2:0] kind, input logic [31:0] id,
                           input logic [1:0] tag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_resource_id <= id;
    in_scope_tag   <= tag;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Register write: setup then access, done when pready is seen
  task automatic write_units(input logic [ssba_pkg::UNITS_W-1:0] value);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[ssba_pkg::UNITS_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ssba_pkg::REG_UNITS, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly activates from a small id pool so hits, evictions and full tables occur
  task automatic send_random(output bit counted);
    int r;
    logic [2:0]  kind;
    logic [31:0] id;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, pool_size - 1)]
                                      : $urandom();
    if (r < 55)      kind = ssba_pkg::KIND_ACTIVATE;
    else if (r < 67) kind = ssba_pkg::KIND_REL_SCOPE;
    else if (r < 79) kind = ssba_pkg::KIND_REL_ID;
    else if (r < 87) kind = ssba_pkg::KIND_DECAY;
    else if (r < 92) kind = ssba_pkg::KIND_CLEAR;
    else if (r < 96) kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    else             kind = 3'($urandom_range(0, 7));
    counted = (kind < KIND_SPARE_FIRST);
    send_item(kind, id, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    bit counted;
    int done_items;
    in_valid       = 1'b0;
    in_kind        = ssba_pkg::KIND_ACTIVATE;
    in_resource_id = '0;
    in_scope_tag   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_n          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at the reset setting of 16 units
    send_item(ssba_pkg::KIND_REL_ID,    32'h0000_0000, 2'd0);  // id 0 hits a cleared slot
    send_item(ssba_pkg::KIND_ACTIVATE,  32'h0000_0000, 2'd0);  // id 0 always rebinds
    send_item(ssba_pkg::KIND_ACTIVATE,  32'hFFFF_FFFF, 2'd3);
    send_item(ssba_pkg::KIND_ACTIVATE,  32'hFFFF_FFFF, 2'd1);  // reuse, no rebind
    send_item(ssba_pkg::KIND_ACTIVATE,  32'h1234_5678, 2'd2);
    send_item(ssba_pkg::KIND_ACTIVATE,  32'h8000_0001, 2'd1);
    send_item(ssba_pkg::KIND_REL_SCOPE, 32'h0000_0000, 2'd1);
    send_item(ssba_pkg::KIND_REL_SCOPE, 32'hFFFF_FFFF, 2'd3);
    send_item(ssba_pkg::KIND_REL_ID,    32'hFFFF_FFFF, 2'd0);  // already unpinned
    send_item(ssba_pkg::KIND_REL_ID,    32'hDEAD_BEEF, 2'd0);  // not found
    send_item(ssba_pkg::KIND_DECAY,     32'h0000_0000, 2'd0);
    send_item(ssba_pkg::KIND_ACTIVATE,  32'h5555_AAAA, 2'd2);  // lowest score wins
    send_item(ssba_pkg::KIND_CLEAR,     32'h0000_0000, 2'd0);
    send_item(ssba_pkg::KIND_ACTIVATE,  32'h0000_0000, 2'd3);  // id 0 after clear
    send_item(ssba_pkg::KIND_ACTIVATE,  32'hAAAA_5555, 2'd0);  // cleared ids still pinned
    send_item(KIND_SPARE_FIRST,         32'hFFFF_FFFF, 2'd3);
    send_item(KIND_SPARE_MID,           32'h0F0F_F0F0, 2'd2);
    send_item(KIND_SPARE_LAST,          32'h0000_0001, 2'd1);
    send_item(ssba_pkg::KIND_REL_SCOPE, 32'h0000_0000, 2'd0);
    send_item(ssba_pkg::KIND_REL_SCOPE, 32'h0000_0000, 2'd2);
    send_item(ssba_pkg::KIND_REL_SCOPE, 32'h0000_0000, 2'd3);

    // Random phases, each at its own unit count and idling style
    foreach (unit_plan[p]) begin
      wait_drained();
      write_units((p == 8) ? ssba_pkg::UNITS_W'($urandom_range(1, 32))
                           : ssba_pkg::UNITS_W'(unit_plan[p]));
      no_idle   = (p % 3 == 1);
      stall_max = no_idle ? 0 : 14;
      pool_size = $urandom_range(4, POOL_MAX);
      foreach (id_pool[i]) id_pool[i] = $urandom();
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        send_random(counted);
        if (counted) done_items++;
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ssba_pkg.sv
rtl/ssba_ram.sv
rtl/ssba_slot_unit.sv
rtl/scored_slot_binding_allocator_core.sv
test/slot_binding_checker.sv
test/scored_slot_binding_allocator_core_tb.sv
